FILE: hdl/hsc_pkg.sv
`timescale 1ns / 1ps

package hsc_pkg;

	localparam int WORD_W  = 64;
	localparam int SYN_W   = 6;
	localparam int ORDER_W = 3;
	localparam int STAT_W  = 2;

	localparam int unsigned MIN_ORDER = 2;
	localparam int unsigned MAX_ORDER = 6;
	localparam logic [ORDER_W-1:0] RESET_ORDER = 3'd3;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_CODE_ORDER = 1'b0;
	localparam logic REG_EXTENDED   = 1'b1;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_CORRECTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_DOUBLE    = 2'd2;

	typedef struct packed {
		logic              opcode;
		logic [WORD_W-1:0] in_word;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_word;
		logic [STAT_W-1:0] status;
		logic [SYN_W-1:0]  syndrome;
	} rsp_t;

	// place data bits, LSB first, at the positions that are not powers of two
	function automatic logic [WORD_W-1:0] scatter(input logic [WORD_W-1:0] data);
		logic [WORD_W-1:0] cw;
		int di;
		cw = '0;
		di = 0;
		for (int p = 1; p < WORD_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				cw[p-1] = data[di];
				di++;
			end
		end
		return cw;
	endfunction

	// pull data bits back out of the non-parity positions
	function automatic logic [WORD_W-1:0] gather(input logic [WORD_W-1:0] cw);
		logic [WORD_W-1:0] data;
		int di;
		data = '0;
		di = 0;
		for (int p = 1; p < WORD_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				data[di] = cw[p-1];
				di++;
			end
		end
		return data;
	endfunction

	// bit r is the XOR of every position whose index has bit r set
	function automatic logic [SYN_W-1:0] syndrome_of(input logic [WORD_W-1:0] cw);
		logic [SYN_W-1:0] syn;
		syn = '0;
		for (int r = 0; r < SYN_W; r++) begin
			for (int p = 1; p < WORD_W; p++) begin
				if (((p >> r) & 1) != 0) begin
					syn[r] = syn[r] ^ cw[p-1];
				end
			end
		end
		return syn;
	endfunction

endpackage

FILE: hdl/hamming_secded_codec.sv
`timescale 1ns / 1ps

// Hamming SEC-DED encoder/decoder, orders 2 to 6, optional overall parity bit.
// Throughput: one word per cycle while rsp_stall is low; four register stages of
// fixed XOR trees (input capture, placement/mask, syndrome and parity,
// correction and extraction) lie between an accepted request and its response on rsp.
// Reset clears all stage valid bits; code_order resets to 3, extended_q to 0.
module hamming_secded_codec (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hsc_pkg::ADDR_W-1:0]   paddr,
	input  logic [hsc_pkg::DATA_W-1:0]   pwdata,
	output logic [hsc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,

	input  logic                         req_valid,
	output logic                         req_stall,
	input  hsc_pkg::req_t                req,

	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output hsc_pkg::rsp_t                rsp
);

	localparam int W = hsc_pkg::WORD_W;
	localparam int S = hsc_pkg::SYN_W;

	// configuration
	logic [hsc_pkg::ORDER_W-1:0] code_order_q;
	logic                        extended_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_order_q <= hsc_pkg::RESET_ORDER;
			extended_q   <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == hsc_pkg::REG_CODE_ORDER) begin
				code_order_q <= pwdata[hsc_pkg::ORDER_W-1:0];
			end else begin
				extended_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == hsc_pkg::REG_CODE_ORDER) begin
			prdata[hsc_pkg::ORDER_W-1:0] = code_order_q;
		end else begin
			prdata[0] = extended_q;
		end
	end

	// effective order, codeword length and mask
	logic [hsc_pkg::ORDER_W-1:0] order_eff;
	logic [S-1:0]                n_len;
	logic [W-1:0]                base_mask;

	always_comb begin
		priority if (code_order_q < hsc_pkg::ORDER_W'(hsc_pkg::MIN_ORDER)) begin
			order_eff = hsc_pkg::ORDER_W'(hsc_pkg::MIN_ORDER);
		end else if (code_order_q > hsc_pkg::ORDER_W'(hsc_pkg::MAX_ORDER)) begin
			order_eff = hsc_pkg::ORDER_W'(hsc_pkg::MAX_ORDER);
		end else begin
			order_eff = code_order_q;
		end
		n_len     = S'((7'd1 << order_eff) - 7'd1);
		base_mask = (W'(1) << n_len) - W'(1);
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4       = !v_s4 || !rsp_stall;
	assign en3       = !v_s3 || en4;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req_stall = !en1;
	assign rsp_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: capture the request
	logic         op_s1;
	logic [W-1:0] word_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1   <= req.opcode;
			word_s1 <= req.in_word;
		end
	end

	// stage 2: place data or mask codeword, grab the overall parity bit
	logic         op_s2;
	logic [W-1:0] cw_s2;
	logic         top_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2  <= op_s1;
			top_s2 <= word_s1[n_len];
			if (op_s1 == hsc_pkg::OP_DECODE) begin
				cw_s2 <= word_s1 & base_mask;
			end else begin
				cw_s2 <= hsc_pkg::scatter(word_s1) & base_mask;
			end
		end
	end

	// stage 3: syndrome and parity over the base codeword
	logic         op_s3;
	logic [W-1:0] cw_s3;
	logic         top_s3;
	logic [S-1:0] syn_s3;
	logic         par_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3  <= op_s2;
			cw_s3  <= cw_s2;
			top_s3 <= top_s2;
			syn_s3 <= hsc_pkg::syndrome_of(cw_s2);
			par_s3 <= ^cw_s2;
		end
	end

	// stage 4: finish encode, or correct and extract on decode
	hsc_pkg::rsp_t rsp_next;
	logic [W-1:0]  enc_cw;
	logic [W-1:0]  dec_cw;
	logic [W-1:0]  flip;
	logic          overall;
	logic          syn_nz;

	always_comb begin
		enc_cw = cw_s3;
		for (int r = 0; r < S; r++) begin
			enc_cw[(1 << r) - 1] = cw_s3[(1 << r) - 1] | syn_s3[r];
		end
		// parity bits add the syndrome's own parity to the data parity
		if (extended_q && (par_s3 ^ (^syn_s3))) begin
			enc_cw = enc_cw | (W'(1) << n_len);
		end

		syn_nz  = syn_s3 != '0;
		overall = par_s3 ^ top_s3;
		flip    = W'(1) << (syn_s3 - S'(1));
		dec_cw  = cw_s3;

		rsp_next.status = hsc_pkg::ST_OK;
		if (extended_q) begin
			priority if (syn_nz && overall) begin
				dec_cw          = cw_s3 ^ flip;
				rsp_next.status = hsc_pkg::ST_CORRECTED;
			end else if (syn_nz) begin
				rsp_next.status = hsc_pkg::ST_DOUBLE;
			end else if (overall) begin
				rsp_next.status = hsc_pkg::ST_CORRECTED;
			end else begin
				rsp_next.status = hsc_pkg::ST_OK;
			end
		end else if (syn_nz) begin
			dec_cw          = cw_s3 ^ flip;
			rsp_next.status = hsc_pkg::ST_CORRECTED;
		end

		if (op_s3 == hsc_pkg::OP_DECODE) begin
			rsp_next.out_word = hsc_pkg::gather(dec_cw);
			rsp_next.syndrome = syn_s3;
		end else begin
			rsp_next.out_word = enc_cw;
			rsp_next.status   = hsc_pkg::ST_OK;
			rsp_next.syndrome = '0;
		end
	end

	hsc_pkg::rsp_t rsp_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			rsp_s4 <= rsp_next;
		end
	end

	assign rsp = rsp_s4;

endmodule
